>>> rtl/tva_pkg.sv
// shared types, constants and state codes for the tree vigor allocation block
package tva_pkg;

  localparam int unsigned MaxModules = 64;
  localparam int unsigned IdxW       = 6;
  localparam int unsigned CntW       = 7;
  localparam int unsigned LightW     = 16;
  localparam int unsigned SumW       = 22;
  localparam int unsigned LamW       = 17;
  localparam int unsigned CwW        = LamW + SumW;     // weight times subtree
  localparam int unsigned DenW       = CwW + IdxW;      // sum over up to 63 children
  localparam int unsigned ProdW      = SumW + CwW;      // vigor times weighted subtree
  localparam int unsigned CwLoW      = 20;
  localparam int unsigned CwHiW      = CwW - CwLoW;
  localparam int unsigned InfoW      = 1 + IdxW + 1 + LightW;

  localparam logic [SumW-1:0] SumMax = {SumW{1'b1}};
  localparam logic [LamW-1:0] OneQ16 = LamW'(65536);

  typedef enum logic [1:0] {
    REG_ROOT_VIGOR_MAX = 2'd0,
    REG_APICAL         = 2'd1,
    REG_APICAL_MATURE  = 2'd2,
    REG_FLOWERING      = 2'd3
  } tva_reg_e;

  // one loaded module after classification
  typedef struct packed {
    logic [IdxW-1:0]   idx;
    logic              store;
    logic              pvalid;
    logic [IdxW-1:0]   par;
    logic              main;
    logic [LightW-1:0] light;
    logic              last;
  } tva_item_t;

  typedef struct packed {
    logic              pvalid;
    logic [IdxW-1:0]   par;
    logic              main;
    logic [LightW-1:0] light;
  } tva_info_t;

  typedef enum logic [4:0] {
    ST_LOAD,
    ST_INIT_RD,
    ST_INIT_WR,
    ST_UP_RD,
    ST_UP_PAR,
    ST_UP_WR,
    ST_DEN_RD,
    ST_DEN_MUL,
    ST_DEN_WR,
    ST_ROOT_RD,
    ST_ROOT_WR,
    ST_VIG_RD,
    ST_VIG_MUL,
    ST_VIG_LO,
    ST_VIG_HI,
    ST_VIG_DIV,
    ST_VIG_WR,
    ST_EMIT_RD,
    ST_EMIT_CAP
  } tva_state_e;

endpackage

>>> rtl/tree_vigor_allocation_top.sv
// top level of the tree vigor allocation block: registers, front end, queue, sequencer
//
//  channel   | direction | payload
//  s_axis    | in        | tdata: has_parent, parent_index, is_main, local_light; tlast: last
//  m_axis    | out       | tdata: module_index, vigor, subtree_light; tlast: last result
//  apb       | in/out    | root_vigor_max, apical_control, apical_control_mature, flowering
//
// loading takes one cycle per module through a four-entry queue
// after the last module: an init pass, a light pass and a denominator pass over the modules,
// a root step, then a multiply and a 22-step divide for each child with a nonzero denominator,
// a zero vigor write for each other module, then a read and a capture per result
// the sequencer stalls the queue while it computes and emits, so input backs up behind it
// a result stall holds only the emit loop; reset clears control state, not the stores
module tree_vigor_allocation_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // has_parent, parent_index[5:0], is_main, local_light[15:0]
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,  // module_index[5:0], vigor[21:0], subtree_light[21:0], 0
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tva_pkg::*;

  logic [SumW-1:0] root_vigor_max_q;
  logic [LamW-1:0] apical_q, apical_mature_q, lam_raw, lambda;
  logic            flowering_q;
  tva_reg_e        reg_sel;

  logic      q_full, push, q_valid, pop;
  tva_item_t item_in, item_out;

  logic [IdxW-1:0] out_index;
  logic [SumW-1:0] out_vigor, out_subtree;

  assign pready  = 1'b1;
  assign reg_sel = tva_reg_e'(paddr[3:2]);

  always_comb begin
    unique case (reg_sel)
      REG_ROOT_VIGOR_MAX: prdata = 32'(root_vigor_max_q);
      REG_APICAL:         prdata = 32'(apical_q);
      REG_APICAL_MATURE:  prdata = 32'(apical_mature_q);
      REG_FLOWERING:      prdata = 32'(flowering_q);
      default:            prdata = '0;
    endcase
    lam_raw = flowering_q ? apical_mature_q : apical_q;
    lambda  = (lam_raw > OneQ16) ? OneQ16 : lam_raw;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_vigor_max_q <= SumMax;
      apical_q         <= LamW'(32768);
      apical_mature_q  <= LamW'(32768);
      flowering_q      <= 1'b0;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        REG_ROOT_VIGOR_MAX: root_vigor_max_q <= pwdata[SumW-1:0];
        REG_APICAL:         apical_q         <= pwdata[LamW-1:0];
        REG_APICAL_MATURE:  apical_mature_q  <= pwdata[LamW-1:0];
        REG_FLOWERING:      flowering_q      <= pwdata[0];
        default: ;
      endcase
    end
  end

  tva_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid),
    .has_parent_i   (s_axis_tdata[0]),
    .parent_index_i (s_axis_tdata[6:1]),
    .is_main_i      (s_axis_tdata[7]),
    .local_light_i  (s_axis_tdata[23:8]),
    .last_i         (s_axis_tlast),
    .q_full_i       (q_full),
    .in_ready_o     (s_axis_tready),
    .push_o         (push),
    .item_o         (item_in)
  );

  tva_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (item_in),
    .pop_i       (pop),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .pop_data_o  (item_out)
  );

  tva_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_valid_i        (q_valid),
    .q_item_i         (item_out),
    .pop_o            (pop),
    .root_vigor_max_i (root_vigor_max_q),
    .lambda_i         (lambda),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .out_index_o      (out_index),
    .out_vigor_o      (out_vigor),
    .out_subtree_o    (out_subtree),
    .out_last_o       (m_axis_tlast)
  );

  assign m_axis_tdata = {6'd0, out_subtree, out_vigor, out_index};

endmodule

>>> rtl/tva_front.sv
// input front end: numbers incoming modules and classifies their parent link
module tva_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic                    has_parent_i,
  input  logic [tva_pkg::IdxW-1:0]   parent_index_i,
  input  logic                    is_main_i,
  input  logic [tva_pkg::LightW-1:0] local_light_i,
  input  logic                    last_i,
  input  logic                    q_full_i,
  output logic                    in_ready_o,
  output logic                    push_o,
  output tva_pkg::tva_item_t      item_o
);
  import tva_pkg::*;

  logic [CntW-1:0] count_q, count_d;
  logic            store;

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;
  assign store      = !count_q[CntW-1];

  always_comb begin
    item_o.idx    = count_q[IdxW-1:0];
    item_o.store  = store;
    // a parent that is not earlier in load order makes the module a root
    item_o.pvalid = has_parent_i && ({1'b0, parent_index_i} < count_q);
    item_o.par    = parent_index_i;
    item_o.main   = is_main_i;
    item_o.light  = local_light_i;
    item_o.last   = last_i;
    count_d = count_q;
    if (push_o) begin
      if (last_i) begin
        count_d = '0;
      end else if (store) begin
        count_d = count_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

endmodule

>>> rtl/tva_queue.sv
// short queue between the front end and the compute sequencer
module tva_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  tva_pkg::tva_item_t push_data_i,
  input  logic               pop_i,
  output logic               full_o,
  output logic               valid_o,
  output tva_pkg::tva_item_t pop_data_o
);
  import tva_pkg::*;

  tva_item_t  slot_q [4];
  logic [1:0] wr_q, rd_q;
  logic [2:0] fill_q;
  logic       do_pop;

  assign full_o     = fill_q[2];
  assign valid_o    = fill_q != 3'd0;
  assign pop_data_o = slot_q[rd_q];
  assign do_pop     = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 2'd1;
      end
      if (do_pop) begin
        rd_q <= rd_q + 2'd1;
      end
      fill_q <= fill_q + 3'(push_i) - 3'(do_pop);
    end
  end

endmodule

>>> rtl/tva_back.sv
// compute sequencer: module stores, light, denominator and vigor passes, result emit
module tva_back (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     q_valid_i,
  input  tva_pkg::tva_item_t       q_item_i,
  output logic                     pop_o,
  input  logic [tva_pkg::SumW-1:0] root_vigor_max_i,
  input  logic [tva_pkg::LamW-1:0] lambda_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [tva_pkg::IdxW-1:0] out_index_o,
  output logic [tva_pkg::SumW-1:0] out_vigor_o,
  output logic [tva_pkg::SumW-1:0] out_subtree_o,
  output logic                     out_last_o
);
  import tva_pkg::*;

  tva_state_e state_q, state_d;

  logic [InfoW-1:0] info_mem [MaxModules];
  logic [SumW-1:0]  sub_mem  [MaxModules];
  logic [DenW-1:0]  den_mem  [MaxModules];
  logic [SumW-1:0]  vig_mem  [MaxModules];

  tva_info_t       info_rd_q;
  logic [SumW-1:0] sub_rd_q, vig_rd_q;
  logic [DenW-1:0] den_rd_q;

  logic [IdxW-1:0] sub_ra, den_ra, vig_ra;
  logic            info_we, sub_we, den_we, vig_we;
  logic [IdxW-1:0] info_wa, sub_wa, den_wa, vig_wa;
  tva_info_t       info_wd;
  logic [SumW-1:0] sub_wd, vig_wd;
  logic [DenW-1:0] den_wd;

  logic [IdxW-1:0]       i_q, i_d, last_q, last_d;
  logic [MaxModules-1:0] den_ok_q, den_ok_d;
  logic [SumW-1:0]       sub_i_q, sub_i_d, vp_q, vp_d;
  logic [CwW-1:0]        cw_q, cw_d;
  logic [DenW-1:0]       den_q, den_d;
  logic [SumW+CwLoW-1:0] p0_q, p0_d;
  logic [DenW-1:0]       rem_q, rem_d;
  logic [SumW-1:0]       ql_q, ql_d;
  logic [4:0]            step_q, step_d;

  logic                  out_valid_q, out_valid_d, out_load;
  logic [IdxW-1:0]       out_index_q;
  logic [SumW-1:0]       out_vigor_q, out_subtree_q;
  logic                  out_last_q;

  logic [LamW-1:0]  weight;
  logic [SumW:0]    up_sum;
  logic [DenW-1:0]  den_cur;
  logic [ProdW-1:0] prod;
  logic [DenW:0]    rem_sh;

  assign out_valid_o   = out_valid_q;
  assign out_index_o   = out_index_q;
  assign out_vigor_o   = out_vigor_q;
  assign out_subtree_o = out_subtree_q;
  assign out_last_o    = out_last_q;

  always_comb begin
    weight  = info_rd_q.main ? lambda_i : (OneQ16 - lambda_i);
    up_sum  = {1'b0, sub_rd_q} + {1'b0, sub_i_q};
    den_cur = den_ok_q[info_rd_q.par] ? den_rd_q : '0;
    prod    = ProdW'(p0_q) + (ProdW'(vp_q * cw_q[CwW-1:CwLoW]) << CwLoW);
    rem_sh  = {rem_q, ql_q[SumW-1]};
  end

  always_comb begin
    state_d     = state_q;
    i_d         = i_q;
    last_d      = last_q;
    den_ok_d    = den_ok_q;
    sub_i_d     = sub_i_q;
    vp_d        = vp_q;
    cw_d        = cw_q;
    den_d       = den_q;
    p0_d        = p0_q;
    rem_d       = rem_q;
    ql_d        = ql_q;
    step_d      = step_q;
    pop_o       = 1'b0;
    out_load    = 1'b0;
    sub_ra      = i_q;
    den_ra      = i_q;
    vig_ra      = i_q;
    info_we     = 1'b0;
    info_wa     = q_item_i.idx;
    info_wd     = '{pvalid: q_item_i.pvalid, par: q_item_i.par,
                    main: q_item_i.main, light: q_item_i.light};
    sub_we      = 1'b0;
    sub_wa      = i_q;
    sub_wd      = SumW'(info_rd_q.light);
    den_we      = 1'b0;
    den_wa      = info_rd_q.par;
    den_wd      = den_cur + DenW'(cw_q);
    vig_we      = 1'b0;
    vig_wa      = i_q;
    vig_wd      = ql_q;

    unique case (state_q)
      ST_LOAD: begin
        pop_o = 1'b1;
        if (q_valid_i) begin
          info_we = q_item_i.store;
          if (q_item_i.last) begin
            last_d   = q_item_i.store ? q_item_i.idx : IdxW'(MaxModules - 1);
            den_ok_d = '0;
            i_d      = '0;
            state_d  = ST_INIT_RD;
          end
        end
      end
      ST_INIT_RD: state_d = ST_INIT_WR;
      ST_INIT_WR: begin
        sub_we = 1'b1;
        if (i_q == last_q) begin
          if (last_q == '0) begin
            state_d = ST_ROOT_RD;
          end else begin
            state_d = ST_UP_RD;
          end
        end else begin
          i_d     = i_q + IdxW'(1);
          state_d = ST_INIT_RD;
        end
      end
      // children lie above their parent, so a descending walk finishes each subtree first
      ST_UP_RD: state_d = ST_UP_PAR;
      ST_UP_PAR: begin
        sub_i_d = sub_rd_q;
        sub_ra  = info_rd_q.par;
        state_d = ST_UP_WR;
      end
      ST_UP_WR: begin
        sub_we = info_rd_q.pvalid;
        sub_wa = info_rd_q.par;
        sub_wd = up_sum[SumW] ? SumMax : up_sum[SumW-1:0];
        if (i_q == IdxW'(1)) begin
          state_d = ST_DEN_RD;
        end else begin
          i_d     = i_q - IdxW'(1);
          state_d = ST_UP_RD;
        end
      end
      ST_DEN_RD: state_d = ST_DEN_MUL;
      ST_DEN_MUL: begin
        cw_d    = weight * sub_rd_q;
        den_ra  = info_rd_q.par;
        state_d = ST_DEN_WR;
      end
      ST_DEN_WR: begin
        if (info_rd_q.pvalid) begin
          den_we                   = 1'b1;
          den_ok_d[info_rd_q.par]  = 1'b1;
        end
        if (i_q == last_q) begin
          state_d = ST_ROOT_RD;
        end else begin
          i_d     = i_q + IdxW'(1);
          state_d = ST_DEN_RD;
        end
      end
      ST_ROOT_RD: begin
        sub_ra  = '0;
        state_d = ST_ROOT_WR;
      end
      ST_ROOT_WR: begin
        vig_we = 1'b1;
        vig_wa = '0;
        vig_wd = (sub_rd_q < root_vigor_max_i) ? sub_rd_q : root_vigor_max_i;
        if (last_q == '0) begin
          i_d     = '0;
          state_d = ST_EMIT_RD;
        end else begin
          i_d     = IdxW'(1);
          state_d = ST_VIG_RD;
        end
      end
      ST_VIG_RD: state_d = ST_VIG_MUL;
      ST_VIG_MUL: begin
        cw_d    = weight * sub_rd_q;
        den_ra  = info_rd_q.par;
        vig_ra  = info_rd_q.par;
        state_d = ST_VIG_LO;
      end
      ST_VIG_LO: begin
        den_d = den_cur;
        vp_d  = vig_rd_q;
        p0_d  = vig_rd_q * cw_q[CwLoW-1:0];
        // roots other than module 0 and children of a zero denominator get no vigor
        if (!info_rd_q.pvalid || den_cur == '0) begin
          vig_we = 1'b1;
          vig_wd = '0;
          if (i_q == last_q) begin
            i_d     = '0;
            state_d = ST_EMIT_RD;
          end else begin
            i_d     = i_q + IdxW'(1);
            state_d = ST_VIG_RD;
          end
        end else begin
          state_d = ST_VIG_HI;
        end
      end
      ST_VIG_HI: begin
        // quotient never exceeds parent vigor, so only its low bits are iterated
        rem_d   = DenW'(prod[ProdW-1:SumW]);
        ql_d    = prod[SumW-1:0];
        step_d  = '0;
        state_d = ST_VIG_DIV;
      end
      ST_VIG_DIV: begin
        if (rem_sh >= {1'b0, den_q}) begin
          rem_d = DenW'(rem_sh - {1'b0, den_q});
          ql_d  = {ql_q[SumW-2:0], 1'b1};
        end else begin
          rem_d = rem_sh[DenW-1:0];
          ql_d  = {ql_q[SumW-2:0], 1'b0};
        end
        step_d = step_q + 5'd1;
        if (step_q == 5'(SumW - 1)) begin
          state_d = ST_VIG_WR;
        end
      end
      ST_VIG_WR: begin
        vig_we = 1'b1;
        if (i_q == last_q) begin
          i_d     = '0;
          state_d = ST_EMIT_RD;
        end else begin
          i_d     = i_q + IdxW'(1);
          state_d = ST_VIG_RD;
        end
      end
      ST_EMIT_RD: state_d = ST_EMIT_CAP;
      ST_EMIT_CAP: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          if (i_q == last_q) begin
            state_d = ST_LOAD;
          end else begin
            i_d     = i_q + IdxW'(1);
            state_d = ST_EMIT_RD;
          end
        end
      end
      default: state_d = ST_LOAD;
    endcase

    out_valid_d = out_load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i) begin
    if (info_we) begin
      info_mem[info_wa] <= info_wd;
    end
    if (sub_we) begin
      sub_mem[sub_wa] <= sub_wd;
    end
    if (den_we) begin
      den_mem[den_wa] <= den_wd;
    end
    if (vig_we) begin
      vig_mem[vig_wa] <= vig_wd;
    end
    info_rd_q <= tva_info_t'(info_mem[i_q]);
    sub_rd_q  <= sub_mem[sub_ra];
    den_rd_q  <= den_mem[den_ra];
    vig_rd_q  <= vig_mem[vig_ra];
  end

  always_ff @(posedge clk_i) begin
    sub_i_q <= sub_i_d;
    vp_q    <= vp_d;
    cw_q    <= cw_d;
    den_q   <= den_d;
    p0_q    <= p0_d;
    rem_q   <= rem_d;
    ql_q    <= ql_d;
    step_q  <= step_d;
    if (out_load) begin
      out_index_q   <= i_q;
      out_vigor_q   <= vig_rd_q;
      out_subtree_q <= sub_rd_q;
      out_last_q    <= i_q == last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      i_q         <= '0;
      last_q      <= '0;
      den_ok_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      i_q         <= i_d;
      last_q      <= last_d;
      den_ok_q    <= den_ok_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

>>> rtl/tva_checker.sv
// port-level checks for the tree vigor allocation block, bound to the top level
module tva_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata,
  input logic        m_axis_tlast,
  input logic        pready
);

  a_pready_high: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[55:50] == 6'd0)
    else $error("result padding not zero");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  a_next_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast ##1 m_axis_tvalid |->
    m_axis_tdata[5:0] == $past(m_axis_tdata[5:0]) + 6'd1)
    else $error("result index did not advance by one");

endmodule

bind tree_vigor_allocation_top tva_checker u_tva_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .pready        (pready)
);
